// ===== rtl/core/eldd_pkg.sv =====
package eldd_pkg;

	// Number of digit modules in the row and LEDs on each module.
	localparam int DIGIT_COUNT    = 8;
	localparam int LEDS_PER_DIGIT = 20;
	localparam int LED_TOTAL      = DIGIT_COUNT * LEDS_PER_DIGIT;

	// Width of an index into the per-position stores.
	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	// Digit code that shows nothing, and the distance between the two LEDs of a digit.
	localparam logic [3:0] DIGIT_BLANK = 4'd15;
	localparam logic [4:0] HALF_OFFSET = 5'd10;
	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_NINE  = 8'd57;

	// The LED index is split by 20 as (index * 205) >> 12, exact for any 8-bit index.
	localparam logic [7:0] DIV20_MUL   = 8'd205;
	localparam int         DIV20_SHIFT = 12;
	localparam int         QUO_W       = 4;

	// Request codes.
	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_PUSH  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_ON    = 3'd3;
	localparam logic [2:0] REQ_OFF   = 3'd4;
	localparam logic [2:0] REQ_READ  = 3'd5;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] char_code;
		logic [2:0] position;
		logic       all_positions;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] led_index;
	} req_t;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic       pixel_lit;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
	} status_t;

	// Offset of the lower lit LED of a digit within its module.
	function automatic logic [4:0] slot_of_digit(input logic [3:0] d);
		logic [4:0] s;
		unique case (d)
			4'd0: s = 5'd3;
			4'd1: s = 5'd4;
			4'd2: s = 5'd2;
			4'd3: s = 5'd0;
			4'd4: s = 5'd8;
			4'd5: s = 5'd6;
			4'd6: s = 5'd5;
			4'd7: s = 5'd7;
			4'd8: s = 5'd9;
			4'd9: s = 5'd1;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/edge_lit_digit_display_controller_unit.sv =====
// A request accepted at a clock edge runs its execute cycle next; a read's
// result is on the result ports, with done high, in the cycle after that execute edge.
// A new request is not taken during the execute step, only once the controller is idle.
// The receiver cannot stall: done is high for exactly one cycle with each read result.
// Reset (arst_n low) blanks every digit, sets all on colors to white and off colors
// to black, and returns the controller to idle with no result pending.
module edge_lit_digit_display_controller_unit
	import eldd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	// The controller sequences each request through a capture step and an execute
	// step; the datapath holds the digit codes and the per-position colors.
	cmd_t    cmd;
	status_t status;

	// The controller raises busy during the execute cycle only, so a new request
	// can be taken in the same cycle as the previous read result is shown.
	eldd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// On capture the datapath latches the request and splits the LED index into
	// its digit position; on execute it applies the update or forms the pixel.
	eldd_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.status  (status),
		.result  (result)
	);

endmodule

// ===== rtl/core/eldd_ctrl.sv =====
module eldd_ctrl
	import eldd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec && status.is_read;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// A result only ever follows an execute cycle.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EXEC))
		else $error("result strobe without a preceding execute cycle");

	// Each request occupies exactly one execute cycle.
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("controller stayed busy for more than one cycle");

	// An accepted request always moves the controller to execute.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && cmd.exec))
		else $error("accepted request did not reach execute");

	// The result appears when the controller is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

endmodule

// ===== rtl/core/eldd_datapath.sv =====
module eldd_datapath
	import eldd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  req_t    request,
	output status_t status,
	output res_t    result
);

	req_t             req_q;
	logic [QUO_W-1:0] quo_q;
	res_t             result_q;

	logic [3:0]  digit_q   [DIGIT_COUNT];
	logic [23:0] on_rgb_q  [DIGIT_COUNT];
	logic [23:0] off_rgb_q [DIGIT_COUNT];

	logic [15:0]      div_prod;
	logic [QUO_W-1:0] quo_d;

	logic             char_ok;
	logic [3:0]       char_digit;
	logic             wr_pos_ok;
	logic [POS_W-1:0] wr_pos;
	logic [23:0]      new_rgb;

	logic [7:0]       base_led;
	logic [7:0]       off_full;
	logic [4:0]       led_off;
	logic             in_range;
	logic [POS_W-1:0] rd_pos;
	logic [3:0]       rd_digit;
	logic [4:0]       slot;
	logic             lit;
	logic [23:0]      rd_rgb;

	// Position of the LED to read, taken from the incoming request.
	assign div_prod = {8'd0, request.led_index} * {8'd0, DIV20_MUL};
	assign quo_d    = div_prod[DIV20_SHIFT +: QUO_W];

	always_comb begin
		char_ok    = (req_q.char_code >= ASCII_ZERO) && (req_q.char_code <= ASCII_NINE);
		char_digit = 4'(req_q.char_code - ASCII_ZERO);
		wr_pos_ok  = ({5'd0, req_q.position} < 8'(DIGIT_COUNT));
		wr_pos     = POS_W'(req_q.position);
		new_rgb    = {req_q.red, req_q.green, req_q.blue};

		base_led = 8'({4'd0, quo_q} * 8'd20);
		off_full = req_q.led_index - base_led;
		led_off  = off_full[4:0];
		in_range = ({8'd0, req_q.led_index} < 16'(LED_TOTAL));
		rd_pos   = POS_W'(quo_q);
		rd_digit = digit_q[rd_pos];
		slot     = slot_of_digit(rd_digit);
		lit      = in_range && (rd_digit < 4'd10) &&
		           ((led_off == slot) || (led_off == (slot + HALF_OFFSET)));
		if (!in_range) begin
			rd_rgb = 24'd0;
		end else if (lit) begin
			rd_rgb = on_rgb_q[rd_pos];
		end else begin
			rd_rgb = off_rgb_q[rd_pos];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
			quo_q <= quo_d;
		end
		if (cmd.exec) begin
			result_q.pixel_red   <= rd_rgb[23:16];
			result_q.pixel_green <= rd_rgb[15:8];
			result_q.pixel_blue  <= rd_rgb[7:0];
			result_q.pixel_lit   <= lit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digit_q[i]   <= DIGIT_BLANK;
				on_rgb_q[i]  <= 24'hFFFFFF;
				off_rgb_q[i] <= 24'h000000;
			end
		end else if (cmd.exec) begin
			unique case (req_q.req_type)
				REQ_CLEAR: begin
					for (int i = 0; i < DIGIT_COUNT; i++) begin
						digit_q[i] <= DIGIT_BLANK;
					end
				end
				REQ_PUSH: begin
					if (char_ok) begin
						for (int i = DIGIT_COUNT - 1; i > 0; i--) begin
							digit_q[i] <= digit_q[i-1];
						end
						digit_q[0] <= char_digit;
					end
				end
				REQ_WRITE: begin
					if (char_ok && wr_pos_ok) begin
						digit_q[wr_pos] <= char_digit;
					end
				end
				REQ_ON: begin
					if (req_q.all_positions) begin
						for (int i = 0; i < DIGIT_COUNT; i++) begin
							on_rgb_q[i] <= new_rgb;
						end
					end else if (wr_pos_ok) begin
						on_rgb_q[wr_pos] <= new_rgb;
					end
				end
				REQ_OFF: begin
					if (req_q.all_positions) begin
						for (int i = 0; i < DIGIT_COUNT; i++) begin
							off_rgb_q[i] <= new_rgb;
						end
					end else if (wr_pos_ok) begin
						off_rgb_q[wr_pos] <= new_rgb;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign status.is_read = (req_q.req_type == REQ_READ);
	assign result         = result_q;

endmodule
